>>> design/rbsi_pkg.sv
// Package of shared word types and constants for the ray versus box slab test.
`timescale 1ns / 1ps

package rbsi_pkg;

   localparam int NUM_AXES = 3;
   localparam int NUM_LANES = 2 * NUM_AXES;
   localparam int FIX_W = 32;

   localparam logic signed [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};
   localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // request word: box corners, ray origin and direction
   typedef struct packed {
      logic signed [FIX_W-1:0] box_min_x;
      logic signed [FIX_W-1:0] box_min_y;
      logic signed [FIX_W-1:0] box_min_z;
      logic signed [FIX_W-1:0] box_max_x;
      logic signed [FIX_W-1:0] box_max_y;
      logic signed [FIX_W-1:0] box_max_z;
      logic signed [FIX_W-1:0] ray_origin_x;
      logic signed [FIX_W-1:0] ray_origin_y;
      logic signed [FIX_W-1:0] ray_origin_z;
      logic signed [FIX_W-1:0] ray_dir_x;
      logic signed [FIX_W-1:0] ray_dir_y;
      logic signed [FIX_W-1:0] ray_dir_z;
   } req_word_type;

   // response word
   typedef struct packed {
      logic                    hit;
      logic signed [FIX_W-1:0] t_near;
      logic signed [FIX_W-1:0] t_far;
      logic [1:0]              near_axis;
      logic [1:0]              far_axis;
   } rsp_word_type;

   // per-axis flags for a parallel ray
   typedef struct packed {
      logic dzero;
      logic outside;
   } axis_flag_type;

   // per-axis slab distances after ordering
   typedef struct packed {
      logic signed [FIX_W-1:0] t1;
      logic signed [FIX_W-1:0] t2;
      axis_flag_type           flg;
   } slab_type;

   // running fold state over the axes
   typedef struct packed {
      logic                    hit;
      logic                    done;
      logic signed [FIX_W-1:0] tn;
      logic signed [FIX_W-1:0] tf;
      logic [1:0]              na;
      logic [1:0]              fa;
   } fold_type;

endpackage

>>> design/ray_box_slab_intersection.sv
// Top level of the pipelined ray versus axis-aligned box slab test.
`timescale 1ns / 1ps

// One word is taken in every cycle that start is high; busy is always low, as
// the pipeline never stalls and the receiver cannot hold results off. Each
// result appears on rsp_word for one cycle with rsp_strobe, in request order.
// Most of the pipeline is the six slab dividers: each yields one quotient bit
// per stage over 32 stages. Around them sit an input register, a numerator
// set-up stage, a sign and saturation stage and three fold stages, one per axis.
module ray_box_slab_intersection #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rbsi_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output rbsi_pkg::rsp_word_type rsp_word
);

   localparam int W = rbsi_pkg::FIX_W;
   localparam int NL = rbsi_pkg::NUM_LANES;
   localparam int NA = rbsi_pkg::NUM_AXES;
   localparam int DS = W;                  // quotient bits, one per stage
   localparam int NUM_W = W + FRAC_BITS;   // numerator magnitude width
   localparam int LAT = DS + 6;            // valid chain length

   assign busy = 1'b0;

   // valid chain
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   // input register
   rbsi_pkg::req_word_type in_ff;
   always_ff @(posedge clock) begin
      in_ff <= req_word;
   end

   logic signed [W-1:0] lo_a [NA];
   logic signed [W-1:0] hi_a [NA];
   logic signed [W-1:0] org_a [NA];
   logic signed [W-1:0] dir_a [NA];
   always_comb begin
      lo_a[0] = in_ff.box_min_x;
      lo_a[1] = in_ff.box_min_y;
      lo_a[2] = in_ff.box_min_z;
      hi_a[0] = in_ff.box_max_x;
      hi_a[1] = in_ff.box_max_y;
      hi_a[2] = in_ff.box_max_z;
      org_a[0] = in_ff.ray_origin_x;
      org_a[1] = in_ff.ray_origin_y;
      org_a[2] = in_ff.ray_origin_z;
      dir_a[0] = in_ff.ray_dir_x;
      dir_a[1] = in_ff.ray_dir_y;
      dir_a[2] = in_ff.ray_dir_z;
   end

   // divider pipeline registers, index 0 is the set-up stage
   logic [W-1:0] rem_ff [NL][DS+1];
   logic [W-1:0] nlo_ff [NL][DS+1];
   logic [W-1:0] quo_ff [NL][DS+1];
   logic [W-1:0] dm_ff  [NL][DS+1];
   logic         neg_ff [NL][DS+1];
   logic         ovf_ff [NL][DS+1];
   rbsi_pkg::axis_flag_type flg_ff [NA][DS+1];

   // per-axis parallel-ray flags, carried beside the divider
   for (genvar a = 0; a < NA; a++) begin : g_flag
      rbsi_pkg::axis_flag_type flg_in;
      always_comb begin
         flg_in.dzero = (dir_a[a] == '0);
         flg_in.outside = (org_a[a] < lo_a[a]) || (org_a[a] > hi_a[a]);
      end
      always_ff @(posedge clock) begin
         flg_ff[a][0] <= flg_in;
      end
      for (genvar s = 1; s <= DS; s++) begin : g_dly
         always_ff @(posedge clock) begin
            flg_ff[a][s] <= flg_ff[a][s-1];
         end
      end
   end

   for (genvar k = 0; k < NL; k++) begin : g_lane
      localparam int AX = k / 2;
      localparam bit UPPER = (k % 2) == 1;

      // set-up: magnitudes, sign, overflow against a 32-bit quotient
      logic signed [W:0]   diff;
      logic [W-1:0]        dmag;
      logic [W-1:0]        dm_in;
      logic [NUM_W-1:0]    num;
      logic [W-1:0]        top;
      always_comb begin
         diff = UPPER ? ((W+1)'(hi_a[AX]) - (W+1)'(org_a[AX]))
                      : ((W+1)'(lo_a[AX]) - (W+1)'(org_a[AX]));
         dmag = diff[W] ? W'(-diff) : W'(diff);
         dm_in = dir_a[AX][W-1] ? W'(-dir_a[AX]) : W'(dir_a[AX]);
         num = {dmag, {FRAC_BITS{1'b0}}};
         top = {{(W-FRAC_BITS){1'b0}}, num[NUM_W-1:W]};
      end
      always_ff @(posedge clock) begin
         rem_ff[k][0] <= top;
         nlo_ff[k][0] <= num[W-1:0];
         quo_ff[k][0] <= '0;
         dm_ff[k][0]  <= dm_in;
         neg_ff[k][0] <= diff[W] ^ dir_a[AX][W-1];
         ovf_ff[k][0] <= (top >= dm_in);
      end

      // restoring division, one quotient bit per stage
      for (genvar s = 0; s < DS; s++) begin : g_div
         logic [W:0]   trial;
         logic [W:0]   diff_r;
         logic [W-1:0] rem_in;
         logic [W-1:0] quo_in;
         always_comb begin
            trial = {rem_ff[k][s], nlo_ff[k][s][W-1]};
            diff_r = trial - {1'b0, dm_ff[k][s]};
            if (trial >= {1'b0, dm_ff[k][s]}) begin
               rem_in = diff_r[W-1:0];
               quo_in = {quo_ff[k][s][W-2:0], 1'b1};
            end else begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[k][s][W-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            rem_ff[k][s+1] <= rem_in;
            nlo_ff[k][s+1] <= {nlo_ff[k][s][W-2:0], 1'b0};
            quo_ff[k][s+1] <= quo_in;
            dm_ff[k][s+1]  <= dm_ff[k][s];
            neg_ff[k][s+1] <= neg_ff[k][s];
            ovf_ff[k][s+1] <= ovf_ff[k][s];
         end
      end
   end

   // sign and saturation per lane
   logic signed [W-1:0] tq [NL];
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         if (ovf_ff[k][DS]) begin
            tq[k] = neg_ff[k][DS] ? rbsi_pkg::FIX_MIN : rbsi_pkg::FIX_MAX;
         end else if (!neg_ff[k][DS]) begin
            tq[k] = quo_ff[k][DS][W-1] ? rbsi_pkg::FIX_MAX : quo_ff[k][DS];
         end else if (quo_ff[k][DS] > {1'b1, {(W-1){1'b0}}}) begin
            tq[k] = rbsi_pkg::FIX_MIN;
         end else begin
            tq[k] = -quo_ff[k][DS];
         end
      end
   end

   // ordered slab distances, then delayed for the later fold stages
   rbsi_pkg::slab_type sat_ff [NA][NA];
   rbsi_pkg::slab_type sat_in [NA];
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         if (tq[2*a] > tq[2*a+1]) begin
            sat_in[a].t1 = tq[2*a+1];
            sat_in[a].t2 = tq[2*a];
         end else begin
            sat_in[a].t1 = tq[2*a];
            sat_in[a].t2 = tq[2*a+1];
         end
         sat_in[a].flg = flg_ff[a][DS];
      end
   end
   always_ff @(posedge clock) begin
      sat_ff[0] <= sat_in;
      for (int s = 1; s < NA; s++) begin
         sat_ff[s] <= sat_ff[s-1];
      end
   end

   // fold one axis per stage: largest entry, smallest exit, early miss
   rbsi_pkg::fold_type fold_ff [NA];
   for (genvar a = 0; a < NA; a++) begin : g_fold
      rbsi_pkg::fold_type src;
      rbsi_pkg::fold_type fold_in;
      rbsi_pkg::slab_type sl;
      always_comb begin
         if (a == 0) begin
            src.hit = 1'b1;
            src.done = 1'b0;
            src.tn = rbsi_pkg::FIX_MIN;
            src.tf = rbsi_pkg::FIX_MAX;
            src.na = rbsi_pkg::AXIS_NONE;
            src.fa = rbsi_pkg::AXIS_NONE;
         end else begin
            src = fold_ff[(a == 0) ? 0 : a-1];
         end
         sl = sat_ff[a][a];
         fold_in = src;
         if (!src.done) begin
            if (sl.flg.dzero) begin
               if (sl.flg.outside) begin
                  fold_in.hit = 1'b0;
                  fold_in.done = 1'b1;
               end
            end else begin
               if (sl.t1 > src.tn) begin
                  fold_in.tn = sl.t1;
                  fold_in.na = 2'(a);
               end
               if (sl.t2 < src.tf) begin
                  fold_in.tf = sl.t2;
                  fold_in.fa = 2'(a);
               end
               if ((fold_in.tn > fold_in.tf) || (fold_in.tf < 0)) begin
                  fold_in.hit = 1'b0;
                  fold_in.done = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         fold_ff[a] <= fold_in;
      end
   end

   // result word
   assign rsp_strobe = vld_ff[LAT-1];
   always_comb begin
      rsp_word.hit = fold_ff[NA-1].hit;
      rsp_word.t_near = fold_ff[NA-1].tn;
      rsp_word.t_far = fold_ff[NA-1].tf;
      rsp_word.near_axis = fold_ff[NA-1].na;
      rsp_word.far_axis = fold_ff[NA-1].fa;
   end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the ray versus box slab intersection block.
`timescale 1ns / 1ps

module tb;

   localparam int LATENCY = 38;
   localparam int FRAC_BITS = 16;
   localparam int NUM_RANDOM = 1030;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   rbsi_pkg::req_word_type req_word = '0;
   logic rsp_strobe;
   rbsi_pkg::rsp_word_type rsp_word;

   rbsi_pkg::req_word_type pending_rays[$];
   rbsi_pkg::rsp_word_type expected_hits[$];
   int fail_count = 0;
   bit stimulus_done = 1'b0;
   longint cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;

   ray_box_slab_intersection #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #1 clock = ~clock;

   // slab distance: exact wide quotient, truncated, saturated
   function automatic logic signed [rbsi_pkg::FIX_W-1:0] slab_distance(
      input logic signed [rbsi_pkg::FIX_W-1:0] bound,
      input logic signed [rbsi_pkg::FIX_W-1:0] org,
      input logic signed [rbsi_pkg::FIX_W-1:0] dir);
      logic signed [63:0] num;
      logic signed [63:0] q;
      num = (64'(bound) - 64'(org)) <<< FRAC_BITS;
      q = num / 64'(dir);
      if (q > 64'(rbsi_pkg::FIX_MAX)) q = 64'(rbsi_pkg::FIX_MAX);
      if (q < 64'(rbsi_pkg::FIX_MIN)) q = 64'(rbsi_pkg::FIX_MIN);
      return q[rbsi_pkg::FIX_W-1:0];
   endfunction

   // expected outcome of one box test
   function automatic rbsi_pkg::rsp_word_type predict_box_test(
      input rbsi_pkg::req_word_type w);
      rbsi_pkg::rsp_word_type r;
      logic signed [rbsi_pkg::FIX_W-1:0] lo[3], hi[3], o[3], d[3];
      logic signed [rbsi_pkg::FIX_W-1:0] t1, t2, s;
      lo = '{w.box_min_x, w.box_min_y, w.box_min_z};
      hi = '{w.box_max_x, w.box_max_y, w.box_max_z};
      o = '{w.ray_origin_x, w.ray_origin_y, w.ray_origin_z};
      d = '{w.ray_dir_x, w.ray_dir_y, w.ray_dir_z};
      r.hit = 1'b1;
      r.t_near = rbsi_pkg::FIX_MIN;
      r.t_far = rbsi_pkg::FIX_MAX;
      r.near_axis = rbsi_pkg::AXIS_NONE;
      r.far_axis = rbsi_pkg::AXIS_NONE;
      for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
         if (d[i] == 0) begin
            if (o[i] < lo[i] || o[i] > hi[i]) begin
               r.hit = 1'b0;
               break;
            end
         end else begin
            t1 = slab_distance(lo[i], o[i], d[i]);
            t2 = slab_distance(hi[i], o[i], d[i]);
            if (t1 > t2) begin
               s = t1; t1 = t2; t2 = s;
            end
            if (t1 > r.t_near) begin
               r.t_near = t1;
               r.near_axis = 2'(i);
            end
            if (t2 < r.t_far) begin
               r.t_far = t2;
               r.far_axis = 2'(i);
            end
            if (r.t_near > r.t_far || r.t_far < 0) begin
               r.hit = 1'b0;
               break;
            end
         end
      end
      return r;
   endfunction

   // random coordinate: mostly modest values, sometimes full range or extremes
   function automatic logic signed [rbsi_pkg::FIX_W-1:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: return rbsi_pkg::FIX_MIN;
         2: return rbsi_pkg::FIX_MAX;
         3: return 0;
         default: return rbsi_pkg::FIX_W'($signed($urandom_range(32'h00200000))
                                          - 32'sh00100000);
      endcase
   endfunction

   function automatic logic signed [rbsi_pkg::FIX_W-1:0] rand_dir();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom;
         2: return $signed($urandom_range(7)) - 3;
         default: return rbsi_pkg::FIX_W'($signed($urandom_range(32'h00040000))
                                          - 32'sh00020000);
      endcase
   endfunction

   // box with ordered corners in most cases, random ray origin and direction
   function automatic rbsi_pkg::req_word_type rand_ray();
      rbsi_pkg::req_word_type w;
      logic signed [rbsi_pkg::FIX_W-1:0] a, b;
      w = '0;
      for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
         a = rand_coord();
         b = rand_coord();
         if ($urandom_range(9) != 0 && a > b) begin
            w[rbsi_pkg::FIX_W*(11-i) +: rbsi_pkg::FIX_W] = b;
            w[rbsi_pkg::FIX_W*(8-i) +: rbsi_pkg::FIX_W] = a;
         end else begin
            w[rbsi_pkg::FIX_W*(11-i) +: rbsi_pkg::FIX_W] = a;
            w[rbsi_pkg::FIX_W*(8-i) +: rbsi_pkg::FIX_W] = b;
         end
         w[rbsi_pkg::FIX_W*(5-i) +: rbsi_pkg::FIX_W] = rand_coord();
         w[rbsi_pkg::FIX_W*(2-i) +: rbsi_pkg::FIX_W] = rand_dir();
      end
      return w;
   endfunction

   // stimulus: directed cases then random rays
   initial begin
      rbsi_pkg::req_word_type w;
      // unit box at origin, ray from -5 along +x
      w = '{32'shFFFF0000, 32'shFFFF0000, 32'shFFFF0000, 32'sh00010000, 32'sh00010000,
            32'sh00010000, 32'shFFFB0000, 0, 0, 32'sh00010000, 0, 0};
      pending_rays.push_back(w);
      w.ray_dir_x = 32'shFFFF0000; pending_rays.push_back(w);      // pointing away
      w.ray_origin_y = 32'sh00050000; pending_rays.push_back(w);   // parallel outside
      w = '{32'shFFFF0000, 32'shFFFF0000, 32'shFFFF0000, 32'sh00010000, 32'sh00010000,
            32'sh00010000, 0, 0, 0, 0, 0, 0};
      pending_rays.push_back(w);                                    // origin inside, all zero dir
      w.ray_dir_z = 1; pending_rays.push_back(w);                   // saturating quotient
      w.ray_dir_z = rbsi_pkg::FIX_MIN; pending_rays.push_back(w);
      w.ray_dir_y = rbsi_pkg::FIX_MAX; w.ray_dir_x = 32'sh00030000; pending_rays.push_back(w);
      w.box_min_x = 32'sh00020000; pending_rays.push_back(w);      // inverted box
      pending_rays.push_back('{rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MIN,
                               rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MAX,
                               rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MAX,
                               1, -1, 1});
      pending_rays.push_back('{rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MAX,
                               rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MIN,
                               rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MAX, rbsi_pkg::FIX_MIN,
                               rbsi_pkg::FIX_MIN, rbsi_pkg::FIX_MAX, -1});
      pending_rays.push_back('1);
      pending_rays.push_back('0);
      // box behind the origin along each axis
      for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
         w = '{32'shFFFF0000, 32'shFFFF0000, 32'shFFFF0000, 32'sh00010000, 32'sh00010000,
               32'sh00010000, 0, 0, 0, 0, 0, 0};
         w[rbsi_pkg::FIX_W*(5-i) +: rbsi_pkg::FIX_W] = 32'sh00050000;
         w[rbsi_pkg::FIX_W*(2-i) +: rbsi_pkg::FIX_W] = 32'sh00010000;
         pending_rays.push_back(w);
      end
      for (int n = 0; n < NUM_RANDOM; n++)
         pending_rays.push_back($urandom_range(7) == 0 ? rbsi_pkg::req_word_type'({$urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom}) : rand_ray());
      stimulus_done = 1'b1;
   end

   // reset and end of run
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (stimulus_done && pending_rays.size() == 0 && !start);
      wait (expected_hits.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // driver: bursts and gaps, changes on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_hits.push_back(predict_box_test(req_word));
            void'(pending_rays.pop_front());
         end
         if (start && busy) begin
            // word still waiting, hold it
         end else if (pending_rays.size() != 0 && gap_left == 0) begin
            start <= 1'b1;
            req_word <= pending_rays[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(40, 1);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end else begin
               burst_left--;
               if (burst_left == 0 && gap_left == 0) burst_left = $urandom_range(40, 1);
            end
         end else begin
            start <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      rbsi_pkg::rsp_word_type e;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_word.hit !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_word.hit); fail_count++;
            end
            if (rsp_word.t_near !== e.t_near) begin
               $error("t_near: expected %h, got %h", e.t_near, rsp_word.t_near); fail_count++;
            end
            if (rsp_word.t_far !== e.t_far) begin
               $error("t_far: expected %h, got %h", e.t_far, rsp_word.t_far); fail_count++;
            end
            if (rsp_word.near_axis !== e.near_axis) begin
               $error("near_axis: expected %0d, got %0d", e.near_axis, rsp_word.near_axis);
               fail_count++;
            end
            if (rsp_word.far_axis !== e.far_axis) begin
               $error("far_axis: expected %0d, got %0d", e.far_axis, rsp_word.far_axis);
               fail_count++;
            end
         end
      end
   end

endmodule

>>> ray_box_slab_intersection.f
design/rbsi_pkg.sv
design/ray_box_slab_intersection.sv
tb/tb.sv
